FILE: design/fat12_pkg.sv
// Shared types, codes and constants of the FAT12 chain allocator.
package fat12_pkg;

  localparam int TABLE_ENTRIES_DEF = 4096;
  localparam int ENTRY_W           = 12;
  localparam int FIRST_CLUSTER     = 2;

  localparam logic [ENTRY_W-1:0] END_OF_CHAIN = 12'hFFF;
  localparam logic [ENTRY_W-1:0] FREE_ENTRY   = 12'h000;

  localparam logic [1:0] MODE_WRITE    = 2'd0;
  localparam logic [1:0] MODE_READ     = 2'd1;
  localparam logic [1:0] MODE_ALLOCATE = 2'd2;

  localparam logic ST_OK       = 1'b0;
  localparam logic ST_NO_SPACE = 1'b1;

  localparam logic [1:0] ADDR_INDEX = 2'd0;
  localparam logic [1:0] ADDR_SCAN  = 2'd1;
  localparam logic [1:0] ADDR_PREV  = 2'd2;

  localparam logic [1:0] WD_VALUE = 2'd0;
  localparam logic [1:0] WD_LINK  = 2'd1;
  localparam logic [1:0] WD_EOC   = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [ENTRY_W-1:0] cluster_index;
    logic [ENTRY_W-1:0] entry_value;
    logic [ENTRY_W-1:0] needed_count;
  } item_t;

  typedef struct packed {
    logic               status;
    logic [ENTRY_W-1:0] read_value;
    logic [ENTRY_W-1:0] first_cluster;
  } result_t;

  typedef struct packed {
    logic       load;
    logic       wr_en;
    logic [1:0] addr_sel;
    logic [1:0] wdata_sel;
    logic       capture;
    logic       set_fail;
    logic       init_scan;
    logic       step_count;
    logic       step_link;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       idx_ok;
    logic       need_zero;
    logic       scan_empty;
    logic       scan_end;
    logic       short_count;
  } stat_t;

endpackage

FILE: design/fat12_ram.sv
// Generic single-port RAM with registered read.
module fat12_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: design/fat12_ctrl.sv
// Controller state machine of the FAT12 chain allocator.
module fat12_ctrl
  import fat12_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  output logic  done,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_WRITE  = 4'd2;
  localparam logic [3:0] S_RADDR  = 4'd3;
  localparam logic [3:0] S_RDATA  = 4'd4;
  localparam logic [3:0] S_ALLOC  = 4'd5;
  localparam logic [3:0] S_RD1    = 4'd6;
  localparam logic [3:0] S_CK1    = 4'd7;
  localparam logic [3:0] S_EVAL   = 4'd8;
  localparam logic [3:0] S_RD2    = 4'd9;
  localparam logic [3:0] S_CK2    = 4'd10;
  localparam logic [3:0] S_TERM   = 4'd11;
  localparam logic [3:0] S_RESP   = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;

  assign busy = (state != S_IDLE);
  assign done = (state == S_RESP);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.mode)
          MODE_WRITE:    state_next = S_WRITE;
          MODE_READ:     state_next = S_RADDR;
          MODE_ALLOCATE: state_next = S_ALLOC;
          default:       state_next = S_RESP;
        endcase
      end
      S_WRITE: begin
        cmd.addr_sel  = ADDR_INDEX;
        cmd.wdata_sel = WD_VALUE;
        cmd.wr_en     = stat.idx_ok;
        state_next    = S_RESP;
      end
      S_RADDR: begin
        cmd.addr_sel = ADDR_INDEX;
        state_next   = S_RDATA;
      end
      S_RDATA: begin
        cmd.capture = 1'b1;
        state_next  = S_RESP;
      end
      S_ALLOC: begin
        if (stat.need_zero) begin
          state_next = S_RESP;
        end else if (stat.scan_empty) begin
          cmd.set_fail = 1'b1;
          state_next   = S_RESP;
        end else begin
          cmd.init_scan = 1'b1;
          state_next    = S_RD1;
        end
      end
      S_RD1: begin
        cmd.addr_sel = ADDR_SCAN;
        state_next   = S_CK1;
      end
      S_CK1: begin
        cmd.step_count = 1'b1;
        state_next     = stat.scan_end ? S_EVAL : S_RD1;
      end
      S_EVAL: begin
        if (stat.short_count) begin
          cmd.set_fail = 1'b1;
          state_next   = S_RESP;
        end else begin
          cmd.init_scan = 1'b1;
          state_next    = S_RD2;
        end
      end
      S_RD2: begin
        cmd.addr_sel = ADDR_SCAN;
        state_next   = S_CK2;
      end
      S_CK2: begin
        cmd.step_link = 1'b1;
        cmd.addr_sel  = ADDR_PREV;
        cmd.wdata_sel = WD_LINK;
        state_next    = stat.scan_end ? S_TERM : S_RD2;
      end
      S_TERM: begin
        cmd.addr_sel  = ADDR_PREV;
        cmd.wdata_sel = WD_EOC;
        cmd.wr_en     = 1'b1;
        state_next    = S_RESP;
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: design/fat12_dp.sv
// Datapath of the FAT12 chain allocator: item and scan registers, table RAM, result.
module fat12_dp
  import fat12_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  item_t              item,
  input  logic               cfg_we,
  input  logic [ENTRY_W-1:0] cfg_data,
  input  cmd_t               cmd,
  output stat_t              stat,
  output result_t            result
);

  localparam int ADDR_W = $clog2(TABLE_ENTRIES);
  localparam logic [ADDR_W-1:0] LAST_ENTRY = ADDR_W'(TABLE_ENTRIES - 1);
  localparam logic [ADDR_W-1:0] SCAN_FIRST = ADDR_W'(FIRST_CLUSTER);

  logic [ENTRY_W-1:0] cluster_count;
  item_t              cur;
  logic [ADDR_W-1:0]  scan_last;
  logic [ADDR_W-1:0]  scan_position;
  logic [ENTRY_W-1:0] found_tally;
  logic [ADDR_W-1:0]  previous_found;
  result_t            res;

  logic [ENTRY_W:0]   last_wide;
  logic [ADDR_W-1:0]  last_calc;
  logic [ADDR_W-1:0]  ram_addr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               ram_we;
  logic               is_free;
  logic [ENTRY_W-1:0] tally_next;
  logic               link_we;

  always_comb begin
    last_wide = {1'b0, cluster_count} + (ENTRY_W+1)'(1);
    if (last_wide > (ENTRY_W+1)'(TABLE_ENTRIES - 1)) begin
      last_calc = LAST_ENTRY;
    end else begin
      last_calc = last_wide[ADDR_W-1:0];
    end
  end

  assign is_free    = (ram_rdata == FREE_ENTRY);
  assign tally_next = found_tally + ENTRY_W'(is_free);
  assign link_we    = cmd.step_link && is_free && (found_tally != '0);

  always_comb begin
    case (cmd.addr_sel)
      ADDR_INDEX: ram_addr = cur.cluster_index[ADDR_W-1:0];
      ADDR_SCAN:  ram_addr = scan_position;
      ADDR_PREV:  ram_addr = previous_found;
      default:    ram_addr = scan_position;
    endcase
    case (cmd.wdata_sel)
      WD_VALUE: ram_wdata = cur.entry_value;
      WD_LINK:  ram_wdata = ENTRY_W'(scan_position);
      WD_EOC:   ram_wdata = END_OF_CHAIN;
      default:  ram_wdata = END_OF_CHAIN;
    endcase
  end

  assign ram_we = cmd.wr_en || link_we;

  fat12_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    stat.mode        = cur.mode;
    stat.idx_ok      = ({1'b0, cur.cluster_index} < (ENTRY_W+1)'(TABLE_ENTRIES));
    stat.need_zero   = (cur.needed_count == '0);
    stat.scan_empty  = (scan_last < SCAN_FIRST);
    stat.scan_end    = (scan_position == scan_last) || (tally_next >= cur.needed_count);
    stat.short_count = (found_tally < cur.needed_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_count  <= '0;
      scan_position  <= '0;
      found_tally    <= '0;
      previous_found <= '0;
    end else begin
      if (cfg_we) begin
        cluster_count <= cfg_data;
      end
      if (cmd.init_scan) begin
        scan_position <= SCAN_FIRST;
        found_tally   <= '0;
      end
      if (cmd.step_count || cmd.step_link) begin
        found_tally <= tally_next;
        if (!stat.scan_end) begin
          scan_position <= scan_position + ADDR_W'(1);
        end
      end
      if (cmd.step_link && is_free) begin
        previous_found <= scan_position;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur       <= item;
      scan_last <= last_calc;
      res       <= '0;
    end
    if (cmd.capture) begin
      res.read_value <= stat.idx_ok ? ram_rdata : '0;
    end
    if (cmd.set_fail) begin
      res.status <= ST_NO_SPACE;
    end
    if (cmd.step_link && is_free && (found_tally == '0)) begin
      res.first_cluster <= ENTRY_W'(scan_position);
    end
  end

  assign result = res;

endmodule

FILE: design/fat12_table_chain_allocator_unit.sv
// Top level of the FAT12 allocation table with chain allocator.
// A write runs through decode and write states, a read through decode, address and data states,
// and an allocate counts free entries, then links them and writes end of chain unless it fails.
// Each scanned entry is read and then checked on the single table RAM port.
// busy stays high through the done cycle, so the next item is taken only after done; done cannot stall.
// Reset clears control, scan_position, found_tally, previous_found and cluster_count; table contents stay undefined.
module fat12_table_chain_allocator_unit
  import fat12_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  item_t              item,
  output logic               done,
  output result_t            result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [ENTRY_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = !busy;

  fat12_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .stat  (stat),
    .cmd   (cmd)
  );

  fat12_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .result   (result)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transaction accepted but block not busy");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe outside a transaction");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_fail_no_head: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_NO_SPACE)) |-> (result.first_cluster == '0))
    else $error("failed allocation returned a chain head");

endmodule

FILE: test/fat12_table_chain_allocator_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the FAT12 table chain allocator: directed table, then random phases.
module fat12_table_chain_allocator_unit_test;
  import fat12_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         LAST_ENTRY  = TABLE_ENTRIES_DEF - 1;
  localparam int         MAX_NEED    = 4094;

  typedef struct packed {
    logic               is_cfg;
    logic               typed;
    item_t              it;
    result_t            want;
    logic [ENTRY_W-1:0] cfg_value;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  item_t              item;
  logic               done;
  result_t            result;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [ENTRY_W-1:0] cfg_data;

  logic [ENTRY_W-1:0] fat_table [TABLE_ENTRIES_DEF];
  bit                 entry_loaded [TABLE_ENTRIES_DEF];
  logic [ENTRY_W-1:0] cluster_count_now = '0;
  result_t            awaited_fat_results [$];
  stim_row_t          directed_rows [$];
  int                 idle_pct = 0;
  int                 items_sent = 0;
  int                 mismatch_count = 0;

  fat12_table_chain_allocator_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int last_scan_cluster();
    int last;
    last = int'(cluster_count_now) + 1;
    if (last > LAST_ENTRY) last = LAST_ENTRY;
    return last;
  endfunction

  function automatic item_t make_item(input logic [1:0] mode, input logic [ENTRY_W-1:0] idx,
                                      input logic [ENTRY_W-1:0] val,
                                      input logic [ENTRY_W-1:0] need);
    item_t it;
    it.mode          = mode;
    it.cluster_index = idx;
    it.entry_value   = val;
    it.needed_count  = need;
    return it;
  endfunction

  function automatic result_t compute_fat_result(input item_t it);
    result_t res;
    int      last;
    int      c;
    int      tally;
    int      prev;
    res = '0;
    case (it.mode)
      MODE_WRITE: begin
        fat_table[it.cluster_index]    = it.entry_value;
        entry_loaded[it.cluster_index] = 1'b1;
      end
      MODE_READ: begin
        res.read_value = fat_table[it.cluster_index];
      end
      MODE_ALLOCATE: begin
        last  = last_scan_cluster();
        tally = 0;
        for (c = FIRST_CLUSTER; c <= last && tally < int'(it.needed_count); c++)
          if (fat_table[c] == FREE_ENTRY) tally++;
        if (tally < int'(it.needed_count)) begin
          res.status = ST_NO_SPACE;
        end else if (it.needed_count != 0) begin
          prev  = 0;
          tally = 0;
          for (c = FIRST_CLUSTER; c <= last && tally < int'(it.needed_count); c++) begin
            if (fat_table[c] == FREE_ENTRY) begin
              if (tally == 0) res.first_cluster = ENTRY_W'(c);
              else fat_table[prev] = ENTRY_W'(c);
              prev = c;
              tally++;
            end
          end
          fat_table[prev] = END_OF_CHAIN;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void add_item_row(input logic typed, input logic [1:0] mode,
                                       input logic [ENTRY_W-1:0] idx,
                                       input logic [ENTRY_W-1:0] val,
                                       input logic [ENTRY_W-1:0] need, input logic status,
                                       input logic [ENTRY_W-1:0] rd,
                                       input logic [ENTRY_W-1:0] first);
    stim_row_t row;
    row                    = '0;
    row.typed              = typed;
    row.it                 = make_item(mode, idx, val, need);
    row.want.status        = status;
    row.want.read_value    = rd;
    row.want.first_cluster = first;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg_row(input logic [ENTRY_W-1:0] value);
    stim_row_t row;
    row           = '0;
    row.is_cfg    = 1'b1;
    row.cfg_value = value;
    directed_rows.push_back(row);
  endfunction

  task automatic issue_item(input item_t it, input logic typed, input result_t want,
                            output result_t predicted);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    predicted = compute_fat_result(it);
    awaited_fat_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic write_cluster_count(input logic [ENTRY_W-1:0] value);
    start <= 1'b0;
    while (awaited_fat_results.size() != 0 || busy) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cluster_count_now = value;
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && done) begin
      if (awaited_fat_results.size() == 0) begin
        $error("unexpected result transaction: status %0d read_value 0x%03h first_cluster 0x%03h",
               result.status, result.read_value, result.first_cluster);
        mismatch_count++;
      end else begin
        want = awaited_fat_results.pop_front();
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          mismatch_count++;
        end
        if (result.read_value !== want.read_value) begin
          $error("read_value: expected 0x%03h, got 0x%03h", want.read_value, result.read_value);
          mismatch_count++;
        end
        if (result.first_cluster !== want.first_cluster) begin
          $error("first_cluster: expected 0x%03h, got 0x%03h", want.first_cluster,
                 result.first_cluster);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : run_stimulus
    result_t            got;
    logic [ENTRY_W-1:0] new_count;
    logic [ENTRY_W-1:0] need;
    logic [ENTRY_W-1:0] link;
    logic [ENTRY_W-1:0] idx;
    logic [ENTRY_W-1:0] cand;
    logic [ENTRY_W-1:0] val;
    logic [ENTRY_W-1:0] chain [$];
    int                 phase;
    int                 phase_items;
    int                 target;
    int                 pick;
    int                 c;
    int                 k;
    bit                 first_alloc;

    rst       <= 1'b1;
    start     <= 1'b0;
    item      <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // cluster_count is zero out of reset
    add_item_row(1'b1, MODE_ALLOCATE, 12'h000, 12'h000, 12'h000, ST_OK, 12'h000, 12'h000);
    add_item_row(1'b1, MODE_ALLOCATE, 12'h000, 12'h000, 12'h001, ST_NO_SPACE, 12'h000, 12'h000);
    add_item_row(1'b1, MODE_ALLOCATE, 12'hFFF, 12'hFFF, 12'hFFE, ST_NO_SPACE, 12'h000, 12'h000);
    add_item_row(1'b1, MODE_UNUSED, 12'hFFF, 12'hFFF, 12'hFFE, ST_OK, 12'h000, 12'h000);
    add_cfg_row(12'd5);
    for (c = 2; c <= 6; c++)
      add_item_row(1'b1, MODE_WRITE, 12'(c), FREE_ENTRY, 12'h000, ST_OK, 12'h000, 12'h000);
    add_item_row(1'b1, MODE_WRITE, 12'h000, 12'hFFF, 12'h000, ST_OK, 12'h000, 12'h000);
    add_item_row(1'b1, MODE_WRITE, 12'hFFF, 12'hFFF, 12'h000, ST_OK, 12'h000, 12'h000);
    add_item_row(1'b1, MODE_READ, 12'hFFF, 12'h000, 12'h000, ST_OK, 12'hFFF, 12'h000);
    add_item_row(1'b1, MODE_READ, 12'h000, 12'h000, 12'h000, ST_OK, 12'hFFF, 12'h000);
    add_item_row(1'b1, MODE_ALLOCATE, 12'h000, 12'h000, 12'd6, ST_NO_SPACE, 12'h000, 12'h000);
    add_item_row(1'b1, MODE_ALLOCATE, 12'h000, 12'h000, 12'd0, ST_OK, 12'h000, 12'h000);
    add_item_row(1'b1, MODE_ALLOCATE, 12'h000, 12'h000, 12'd2, ST_OK, 12'h000, 12'd2);
    add_item_row(1'b0, MODE_READ, 12'd2, 12'h000, 12'h000, ST_OK, 12'h000, 12'h000);
    add_item_row(1'b0, MODE_READ, 12'd3, 12'h000, 12'h000, ST_OK, 12'h000, 12'h000);
    add_item_row(1'b1, MODE_ALLOCATE, 12'h000, 12'h000, 12'd3, ST_OK, 12'h000, 12'd4);
    add_item_row(1'b1, MODE_ALLOCATE, 12'h000, 12'h000, 12'd1, ST_NO_SPACE, 12'h000, 12'h000);
    add_item_row(1'b1, MODE_WRITE, 12'd3, FREE_ENTRY, 12'h000, ST_OK, 12'h000, 12'h000);
    add_item_row(1'b1, MODE_ALLOCATE, 12'h000, 12'h000, 12'd1, ST_OK, 12'h000, 12'd3);
    add_item_row(1'b0, MODE_READ, 12'd6, 12'h000, 12'h000, ST_OK, 12'h000, 12'h000);
    add_item_row(1'b1, MODE_UNUSED, 12'h000, 12'h000, 12'h000, ST_OK, 12'h000, 12'h000);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) write_cluster_count(directed_rows[i].cfg_value);
      else issue_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want, got);
    end

    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          new_count = 12'($urandom_range(8, 16)); idle_pct = 0; phase_items = 20;
        end
        1: begin
          new_count = 12'($urandom_range(17, 24)); idle_pct = 25; phase_items = 12;
        end
        2: begin
          new_count = 12'($urandom_range(1, 20)); idle_pct = 60; phase_items = 20;
        end
        3: begin
          new_count = 12'd0; idle_pct = 25; phase_items = 8;
        end
        default: begin
          new_count = 12'($urandom_range(2, 12)); idle_pct = 25; phase_items = 15;
        end
      endcase
      write_cluster_count(new_count);

      // load every allocatable entry before any scan can reach it
      for (c = FIRST_CLUSTER; c <= last_scan_cluster(); c++)
        if (!entry_loaded[c])
          issue_item(make_item(MODE_WRITE, 12'(c), FREE_ENTRY, 12'($urandom_range(0, MAX_NEED))),
                     1'b0, '0, got);

      target      = items_sent + phase_items;
      first_alloc = 1'b1;
      while (items_sent < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          if (phase == 1) need = first_alloc ? 12'(MAX_NEED) : 12'($urandom_range(0, 6));
          else if ($urandom_range(0, 99) < 20) need = 12'($urandom_range(0, MAX_NEED));
          else need = 12'($urandom_range(0, 5));
          first_alloc = 1'b0;
          issue_item(make_item(MODE_ALLOCATE, 12'($urandom), 12'($urandom), need), 1'b0, '0, got);
          chain.delete();
          link = got.first_cluster;
          if (got.status == ST_OK && need != 0) begin
            // walk the new chain, then free it half of the time
            while (link != END_OF_CHAIN && chain.size() < int'(need)) begin
              chain.push_back(link);
              issue_item(make_item(MODE_READ, link, 12'($urandom),
                                   12'($urandom_range(0, MAX_NEED))), 1'b0, '0, got);
              link = got.read_value;
            end
            if ($urandom_range(0, 1) == 1)
              foreach (chain[j])
                issue_item(make_item(MODE_WRITE, chain[j], FREE_ENTRY,
                                     12'($urandom_range(0, MAX_NEED))), 1'b0, '0, got);
          end
        end else if (pick < 70) begin
          if ($urandom_range(0, 99) < 70) idx = 12'($urandom_range(0, last_scan_cluster() + 1));
          else idx = 12'($urandom);
          k = $urandom_range(0, 99);
          if (k < 50) val = FREE_ENTRY;
          else if (k < 80) val = 12'($urandom);
          else val = END_OF_CHAIN;
          issue_item(make_item(MODE_WRITE, idx, val, 12'($urandom_range(0, MAX_NEED))),
                     1'b0, '0, got);
        end else if (pick < 92) begin
          idx = 12'(LAST_ENTRY);
          for (k = 0; k < 16; k++) begin
            if ($urandom_range(0, 99) < 60)
              cand = 12'($urandom_range(0, last_scan_cluster() + 1));
            else cand = 12'($urandom);
            if (entry_loaded[cand]) begin
              idx = cand;
              break;
            end
          end
          issue_item(make_item(MODE_READ, idx, 12'($urandom), 12'($urandom_range(0, MAX_NEED))),
                     1'b0, '0, got);
        end else begin
          issue_item(make_item(MODE_UNUSED, 12'($urandom), 12'($urandom),
                               12'($urandom_range(0, MAX_NEED))), 1'b0, '0, got);
        end
      end
    end

    start <= 1'b0;
    while (awaited_fat_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
